// ===== rtl/booth_radix2_signed_multiplier_defines.svh =====
// Assertion macros for the Booth multiplier RTL (used by brsm_ctrl).
// No dependencies; files that assert take this header by include.
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_DEFINES_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define BRSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while i_rst_n is low.
`define BRSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/brsm_pkg.sv =====
// Shared types and constants for the Booth radix-2 multiplier.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package brsm_pkg;

    localparam int IN_W          = 16;  // request operand field width
    localparam int OUT_W         = 32;  // product field width
    localparam int WIDTH_DEFAULT = 16;  // operand width used by the recoding

    // Booth pair {current multiplier bit, previous bit}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic load;     // take new operands, clear accumulator
        logic step;     // one add/subtract and shift pass
        logic capture;  // move finished product into output register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/brsm_if.sv =====
// Valid/ready channel interfaces for operand requests and product results.
// Depends on brsm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface brsm_req_if;
    logic                             valid;
    logic                             ready;
    logic signed [brsm_pkg::IN_W-1:0] multiplicand;
    logic signed [brsm_pkg::IN_W-1:0] multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface brsm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [brsm_pkg::OUT_W-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

`default_nettype wire

// ===== rtl/brsm_ctrl.sv =====
// Controller FSM: request handshake, pass counter, output register valid.
// Depends on brsm_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "booth_radix2_signed_multiplier_defines.svh"

module brsm_ctrl #(
    parameter int WIDTH = brsm_pkg::WIDTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output brsm_pkg::t_dp_cmd   o_cmd
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    brsm_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;
    logic             last_pass;

    assign out_free   = !r_out_valid || i_out_ready;
    assign last_pass  = (r_cnt == CW'(WIDTH - 1));
    assign o_in_ready = (r_state == brsm_pkg::ST_IDLE) ||
                        ((r_state == brsm_pkg::ST_DONE) && out_free);
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.load    = accept;
    assign o_cmd.step    = (r_state == brsm_pkg::ST_RUN);
    assign o_cmd.capture = (r_state == brsm_pkg::ST_DONE) && out_free;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brsm_pkg::ST_IDLE: begin
                if (accept) n_state = brsm_pkg::ST_RUN;
            end
            brsm_pkg::ST_RUN: begin
                if (last_pass) n_state = brsm_pkg::ST_DONE;
            end
            brsm_pkg::ST_DONE: begin
                if (out_free) n_state = accept ? brsm_pkg::ST_RUN : brsm_pkg::ST_IDLE;
            end
            default: n_state = brsm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = '0;
        end else if (o_cmd.step) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brsm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `BRSM_ASSERT_NEXT(a_accept_starts_run, accept, (r_state == brsm_pkg::ST_RUN) && (r_cnt == '0), "accepted request did not start the passes")
    `BRSM_ASSERT_NOW(a_capture_when_free, o_cmd.capture, !r_out_valid || i_out_ready, "capture would overwrite an untaken product")
    `BRSM_ASSERT_NEXT(a_capture_sets_valid, o_cmd.capture, r_out_valid, "captured product not presented")
    `BRSM_ASSERT_NOW(a_cnt_in_range, r_state == brsm_pkg::ST_RUN, r_cnt <= CW'(WIDTH - 1), "pass counter ran past the last pass")

endmodule

`default_nettype wire

// ===== rtl/brsm_dp.sv =====
// Datapath: guarded accumulator, multiplier shift register, Booth add/subtract.
// Depends on brsm_pkg for widths, Booth pair codes and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module brsm_dp #(
    parameter int WIDTH = brsm_pkg::WIDTH_DEFAULT
) (
    input  wire                                i_clk,
    input  brsm_pkg::t_dp_cmd                  i_cmd,
    input  wire signed [brsm_pkg::IN_W-1:0]    i_multiplicand,
    input  wire signed [brsm_pkg::IN_W-1:0]    i_multiplier,
    output logic signed [brsm_pkg::OUT_W-1:0]  o_product
);

    localparam int PW = 2 * WIDTH + 1;

    logic signed [WIDTH-1:0]       r_m;
    logic        [WIDTH:0]         r_acc;
    logic        [WIDTH-1:0]       r_q;
    logic                          r_prev;
    logic signed [brsm_pkg::OUT_W-1:0] r_product;

    logic [WIDTH:0]   m_ext;
    logic [WIDTH:0]   sum;
    logic [PW-1:0]    full;
    logic signed [63:0] wide;

    assign m_ext = {r_m[WIDTH-1], r_m};

    always_comb begin
        unique case ({r_q[0], r_prev})
            brsm_pkg::BOOTH_SUB: sum = r_acc - m_ext;
            brsm_pkg::BOOTH_ADD: sum = r_acc + m_ext;
            default:             sum = r_acc;
        endcase
    end

    // Accumulator carries a guard bit, so the full product is PW bits wide.
    assign full = {r_acc, r_q};
    assign wide = 64'(signed'(full));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m    <= WIDTH'(i_multiplicand);
            r_q    <= WIDTH'(i_multiplier);
            r_acc  <= '0;
            r_prev <= 1'b0;
        end else if (i_cmd.step) begin
            r_prev <= r_q[0];
            r_q    <= {sum[0], r_q[WIDTH-1:1]};
            r_acc  <= {sum[WIDTH], sum[WIDTH:1]};
        end
        if (i_cmd.capture) begin
            r_product <= wide[brsm_pkg::OUT_W-1:0];
        end
    end

    assign o_product = r_product;

endmodule

`default_nettype wire

// ===== rtl/booth_radix2_signed_multiplier.sv =====
// Booth radix-2 signed multiplier: an accepted request runs WIDTH passes, then
// one capture into the output register makes the product valid; 16 passes by
// default. One request is multiplied at a time, set by the single add/subtract
// unit doing one pass per multiplier bit. The output register lets the next
// request start while a product waits. Reset (i_rst_n, synchronous, active
// low) returns the controller to idle and drops any pending product.
`timescale 1ns / 1ps
`default_nettype none

module booth_radix2_signed_multiplier #(
    parameter int WIDTH = brsm_pkg::WIDTH_DEFAULT
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    brsm_req_if.sink  i_req,
    brsm_rsp_if.source o_rsp
);

    brsm_pkg::t_dp_cmd cmd;

    // Controller: owns the handshakes and counts the WIDTH Booth passes.
    brsm_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Datapath: load operands on request accept, advance one pass per step,
    // hold the finished product in its output register until taken.
    brsm_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_multiplicand (i_req.multiplicand),
        .i_multiplier   (i_req.multiplier),
        .o_product      (o_rsp.product)
    );

endmodule

`default_nettype wire

// ===== sim/booth_radix2_signed_multiplier_checker.sv =====
// Product checker for the Booth radix-2 multiplier: watches both channels,
// predicts each product and compares it. Depends on brsm_pkg and brsm_if.
`timescale 1ns / 1ps

module booth_radix2_signed_multiplier_checker
    import brsm_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    brsm_req_if  i_req,
    brsm_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_pending
);

    logic signed [OUT_W-1:0] product_q[$];
    logic signed [OUT_W-1:0] want_product;

    // Sequential Booth recoding at WIDTH bits, with guard bits on the accumulator.
    function automatic logic signed [OUT_W-1:0] booth_product(
        input logic signed [IN_W-1:0] mcand,
        input logic signed [IN_W-1:0] mplier
    );
        logic signed [63:0]      wide_mc;
        logic signed [63:0]      wide_mp;
        logic signed [WIDTH:0]   mc;
        logic signed [WIDTH+1:0] acc;
        logic [WIDTH-1:0]        q;
        logic                    prev_bit;
        logic signed [95:0]      joined;
        wide_mc  = mcand;
        wide_mp  = mplier;
        mc       = {wide_mc[WIDTH-1], wide_mc[WIDTH-1:0]};
        q        = wide_mp[WIDTH-1:0];
        acc      = '0;
        prev_bit = 1'b0;
        for (int i = 0; i < WIDTH; i++) begin
            case ({q[0], prev_bit})
                BOOTH_SUB: acc = acc - mc;
                BOOTH_ADD: acc = acc + mc;
                default:   ;
            endcase
            prev_bit = q[0];
            q        = {acc[0], q[WIDTH-1:1]};
            acc      = acc >>> 1;
        end
        joined = $signed({acc, q});
        return joined[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            product_q.delete();
        end else begin
            // Retire a product before queuing a new request of the same edge.
            if (i_rsp.valid && i_rsp.ready) begin
                if (product_q.size() == 0) begin
                    $error("product unexpected: actual %0d", i_rsp.product);
                    o_mismatches++;
                end else begin
                    want_product = product_q.pop_front();
                    if (i_rsp.product !== want_product) begin
                        $error("product mismatch: expected %0d, actual %0d",
                               want_product, i_rsp.product);
                        o_mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                product_q.push_back(booth_product(i_req.multiplicand, i_req.multiplier));
        end
        o_pending = product_q.size();
    end

endmodule

// ===== sim/booth_radix2_signed_multiplier_tb.sv =====
// Testbench top for the Booth radix-2 multiplier: drives operand requests and
// result backpressure, gives the verdict. Depends on brsm_pkg, brsm_if, checker.
`timescale 1ns / 1ps

module booth_radix2_signed_multiplier_tb;
    import brsm_pkg::*;

    localparam int RANDOM_REQUESTS = 1400;
    localparam int DRAIN_CYCLES    = WIDTH_DEFAULT + 8;
    localparam int IDLE_PERCENT    = 36;
    // Hold both sides busy-free for this window of requests.
    localparam int CALM_FIRST      = 500;
    localparam int CALM_LAST       = 800;

    localparam logic signed [IN_W-1:0] OP_MIN = 16'sh8000;
    localparam logic signed [IN_W-1:0] OP_MAX = 16'sh7fff;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   mismatches;
    int   pending;
    int   sent;
    bit   calm;

    brsm_req_if req_ch();
    brsm_rsp_if rsp_ch();

    booth_radix2_signed_multiplier i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    booth_radix2_signed_multiplier_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Draw one operand: mostly full range, some near zero, some at the rails or at 0 and +-1.
    function automatic logic signed [IN_W-1:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return IN_W'($urandom);
        else if (roll < 85)
            return IN_W'($urandom_range(0, 16) - 8);
        case ($urandom_range(0, 4))
            0:       return OP_MIN;
            1:       return OP_MAX;
            2:       return '0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // Issue one request. Entered and left at a falling edge; each falling edge
    // sees exactly one update of valid, so valid never glitches within a step.
    task automatic send_request(input logic signed [IN_W-1:0] mcand,
                                input logic signed [IN_W-1:0] mplier);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            // Drop valid and scramble the payload: the block must ignore it.
            req_ch.valid        <= 1'b0;
            req_ch.multiplicand <= IN_W'($urandom);
            req_ch.multiplier   <= IN_W'($urandom);
            @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.multiplicand <= mcand;
        req_ch.multiplier   <= mplier;
        // Hold the request until the block takes it.
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
        calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);
        @(negedge i_clk);
    endtask

    // Result side: stall at random, except inside the calm window.
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.multiplicand = '0;
        req_ch.multiplier   = '0;
        sent                = 0;
        calm                = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed requests: rails, zero, sign flips, and multipliers that
        // force long runs of adds, subtracts or alternating add/subtract.
        send_request(OP_MIN, OP_MIN);
        send_request(OP_MIN, OP_MAX);
        send_request(OP_MAX, OP_MIN);
        send_request(OP_MAX, OP_MAX);
        send_request('0, '0);
        send_request('0, OP_MIN);
        send_request(OP_MIN, '0);
        send_request(-16'sd1, -16'sd1);
        send_request(16'sd1, -16'sd1);
        send_request(-16'sd1, 16'sd1);
        send_request(OP_MIN, -16'sd1);
        send_request(OP_MIN, 16'sd1);
        send_request(16'sh1234, 16'sh5555);
        send_request(-16'sh1234, 16'shaaaa);
        send_request(OP_MAX, 16'sh0001);
        send_request(OP_MIN, 16'sh8000);
        send_request(16'sh0f0f, 16'sh00ff);
        send_request(-16'sd7, 16'sh7ffe);
        send_request(16'shffff, 16'sh0000);
        send_request(16'sh0001, 16'sh0001);

        // Random requests.
        repeat (RANDOM_REQUESTS) send_request(pick_operand(), pick_operand());

        req_ch.valid <= 1'b0;

        // Advance until every predicted product has come back, then drain.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with both sides stalling.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
